// ===== hdl/lcas_pkg.sv =====
// types and constants shared by the life cellular automaton step block
`timescale 1ns / 1ps

package lcas_pkg;

    localparam int OUT_ROW_W = 10;
    localparam int OUT_COL_W = 6;
    localparam int CFG_W_BITS = 7;
    localparam int CFG_H_BITS = 11;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic KIND_CELL  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic kind;
        logic cell_alive;
    } in_item_t;

    typedef struct packed {
        logic                 next_alive;
        logic [OUT_ROW_W-1:0] out_row;
        logic [OUT_COL_W-1:0] out_col;
        logic                 last_of_frame;
    } out_item_t;

endpackage

// ===== hdl/life_cellular_automaton_step_top.sv =====
// one generation of the b3/s23 life rule over a raster cell stream
//
//  channel   direction  handshake                    payload
//  in        sink       in_valid / in_ready          lcas_pkg::in_item_t
//  out       source     out_valid / out_ready        lcas_pkg::out_item_t
//  cfg       apb slave  psel / penable / pready      grid_width, grid_height
//
// one item per cycle while in_ready is high; each transaction updates the line memory and window in
// the cycle it is taken and its result sits in the output register next cycle
// the line memory is a 2-bit wide single write port ram with a prefetched
// registered read; per-entry valid flags make it read as zero after reset
// in_ready drops only while a result waits in the output register unread
`timescale 1ns / 1ps

module life_cellular_automaton_step_top #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  lcas_pkg::in_item_t                  in_data,

    output logic                                out_valid,
    input  logic                                out_ready,
    output lcas_pkg::out_item_t                 out_data,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcas_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lcas_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lcas_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int GW_W = $clog2(MAX_WIDTH + 1);
    localparam int GH_W = $clog2(MAX_HEIGHT + 1);
    localparam int GW_RESET = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
    localparam int GH_RESET = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;

    localparam logic [1:0] ROW_FIRST  = 2'd0;
    localparam logic [1:0] ROW_SECOND = 2'd1;
    localparam logic [1:0] ROW_LATER  = 2'd2;

    // configuration
    logic [GW_W-1:0] grid_width_reg;
    logic [GW_W-1:0] grid_width_next;
    logic [GH_W-1:0] grid_height_reg;
    logic [GH_W-1:0] grid_height_next;
    logic            cfg_write;
    logic [lcas_pkg::CFG_W_BITS-1:0] wr_w;
    logic [lcas_pkg::CFG_H_BITS-1:0] wr_h;

    // stream position
    logic [CW-1:0] in_col_reg;
    logic [CW-1:0] in_col_next;
    logic [1:0]    in_row_reg;
    logic [1:0]    in_row_next;
    logic [CW-1:0] emit_col_reg;
    logic [CW-1:0] emit_col_next;
    logic [RW-1:0] emit_row_reg;
    logic [RW-1:0] emit_row_next;

    // line memory, entry bit 1 two rows up, bit 0 one row up
    logic [1:0]           line_mem [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] line_vld_reg;
    logic [1:0]           line_q_reg;
    logic                 line_q_vld_reg;
    logic [1:0]           line_rd;
    logic [1:0]           line_wr;
    logic [CW-1:0]        rd_addr;
    logic                 fwd;

    logic [8:0] window_reg;
    logic [8:0] window_next;

    // output register
    logic                out_vld_reg;
    logic                out_vld_next;
    lcas_pkg::out_item_t out_reg;

    logic          accept;
    logic          cell_bit;
    logic          emit;
    logic [CW:0]   in_col_p1;
    logic [CW:0]   emit_col_p1;
    logic [RW:0]   emit_row_p1;
    logic          has_up;
    logic          has_down;
    logic          has_left;
    logic          has_right;
    logic [3:0]    count;
    logic          alive;
    logic          last;
    logic          in_col_wrap;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign wr_w      = pwdata[lcas_pkg::CFG_W_BITS-1:0];
    assign wr_h      = pwdata[lcas_pkg::CFG_H_BITS-1:0];

    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                lcas_pkg::REG_GRID_WIDTH:
                begin
                    if (wr_w == '0)
                        grid_width_next = GW_W'(1);
                    else if (int'(wr_w) > MAX_WIDTH)
                        grid_width_next = GW_W'(MAX_WIDTH);
                    else
                        grid_width_next = GW_W'(wr_w);
                end
                lcas_pkg::REG_GRID_HEIGHT:
                begin
                    if (wr_h == '0)
                        grid_height_next = GH_W'(1);
                    else if (int'(wr_h) > MAX_HEIGHT)
                        grid_height_next = GH_W'(MAX_HEIGHT);
                    else
                        grid_height_next = GH_W'(wr_h);
                end
                default:
                begin
                    grid_width_next = grid_width_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            lcas_pkg::REG_GRID_WIDTH:  prdata = lcas_pkg::APB_DATA_W'(grid_width_reg);
            lcas_pkg::REG_GRID_HEIGHT: prdata = lcas_pkg::APB_DATA_W'(grid_height_reg);
            default:                   prdata = '0;
        endcase
    end

    assign in_ready = ~out_vld_reg | out_ready;
    assign accept   = in_valid & in_ready;
    assign cell_bit = (in_data.kind == lcas_pkg::KIND_FLUSH) ? 1'b0 : in_data.cell_alive;

    assign line_rd = line_q_vld_reg ? line_q_reg : 2'b00;
    assign line_wr = {line_rd[0], cell_bit};

    // new column: bit 6 two rows up, bit 7 one row up, bit 8 this cell
    assign window_next = {cell_bit, line_rd[0], line_rd[1], window_reg[8:3]};

    assign emit = (in_row_reg == ROW_LATER) ||
                  ((in_row_reg == ROW_SECOND) && (in_col_reg != '0));

    assign in_col_p1   = {1'b0, in_col_reg} + 1'b1;
    assign emit_col_p1 = {1'b0, emit_col_reg} + 1'b1;
    assign emit_row_p1 = {1'b0, emit_row_reg} + 1'b1;
    assign has_up      = emit_row_reg != '0;
    assign has_down    = emit_row_p1 < grid_height_reg;
    assign has_left    = emit_col_reg != '0;
    assign has_right   = emit_col_p1 < grid_width_reg;
    assign in_col_wrap = in_col_p1 >= grid_width_reg;

    always_comb
    begin
        count = 4'd0;
        if (has_left)
        begin
            count = count + 4'(window_next[0] & has_up) + 4'(window_next[1])
                          + 4'(window_next[2] & has_down);
        end
        count = count + 4'(window_next[3] & has_up) + 4'(window_next[5] & has_down);
        if (has_right)
        begin
            count = count + 4'(window_next[6] & has_up) + 4'(window_next[7])
                          + 4'(window_next[8] & has_down);
        end
    end

    assign alive = (count == 4'd3) || (window_next[4] && (count == 4'd2));
    assign last  = ~has_down & ~has_right;

    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        emit_col_next = emit_col_reg;
        emit_row_next = emit_row_reg;
        if (cfg_write)
        begin
            in_col_next   = '0;
            in_row_next   = ROW_FIRST;
            emit_col_next = '0;
            emit_row_next = '0;
        end
        else if (accept)
        begin
            if (emit && last)
            begin
                in_col_next   = '0;
                in_row_next   = ROW_FIRST;
                emit_col_next = '0;
                emit_row_next = '0;
            end
            else
            begin
                if (emit)
                begin
                    if (has_right)
                        emit_col_next = emit_col_p1[CW-1:0];
                    else
                    begin
                        emit_col_next = '0;
                        emit_row_next = emit_row_p1[RW-1:0];
                    end
                end
                if (in_col_wrap)
                begin
                    in_col_next = '0;
                    if (in_row_reg != ROW_LATER)
                        in_row_next = in_row_reg + 2'd1;
                end
                else
                    in_col_next = in_col_p1[CW-1:0];
            end
        end
    end

    // prefetch the entry the next transaction will need
    assign rd_addr = in_col_next;
    assign fwd     = accept && (rd_addr == in_col_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
            line_mem[in_col_reg] <= line_wr;
        line_q_reg <= fwd ? line_wr : line_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_vld_reg   <= '0;
            line_q_vld_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                line_vld_reg[in_col_reg] <= 1'b1;
            line_q_vld_reg <= fwd | line_vld_reg[rd_addr];
        end
    end

    assign out_vld_next = (accept && emit) ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GW_W'(GW_RESET);
            grid_height_reg <= GH_W'(GH_RESET);
            in_col_reg      <= '0;
            in_row_reg      <= ROW_FIRST;
            emit_col_reg    <= '0;
            emit_row_reg    <= '0;
            window_reg      <= '0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            in_col_reg      <= in_col_next;
            in_row_reg      <= in_row_next;
            emit_col_reg    <= emit_col_next;
            emit_row_reg    <= emit_row_next;
            if (accept)
                window_reg <= window_next;
            out_vld_reg     <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_reg.next_alive    <= alive;
            out_reg.out_row       <= lcas_pkg::OUT_ROW_W'(emit_row_reg);
            out_reg.out_col       <= lcas_pkg::OUT_COL_W'(emit_col_reg);
            out_reg.last_of_frame <= last;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule
